>>> src/tcfsm_pkg.sv
// Shared types, constants and helpers for the TCP client connection unit.
package tcfsm_pkg;

	localparam int unsigned CfgAddrW = 3;
	localparam int unsigned CfgDataW = 32;
	localparam int unsigned InDataW  = 88;
	localparam int unsigned OutDataW = 88;

	typedef enum logic [CfgAddrW-1:0] {
		CFG_INITIAL_SEQ = 3'd0,
		CFG_LOCAL_IP    = 3'd1,
		CFG_REMOTE_IP   = 3'd2,
		CFG_LOCAL_PORT  = 3'd3,
		CFG_REMOTE_PORT = 3'd4
	} cfg_addr_t;

	localparam logic [31:0] RST_INITIAL_SEQ = 32'h1234_5678;
	localparam logic [31:0] RST_LOCAL_IP    = 32'h0A00_020F;
	localparam logic [31:0] RST_REMOTE_IP   = 32'h0A00_0202;
	localparam logic [15:0] RST_LOCAL_PORT  = 16'd12345;
	localparam logic [15:0] RST_REMOTE_PORT = 16'd80;

	localparam logic CMD_CONNECT = 1'b0;
	localparam logic CMD_SEGMENT = 1'b1;

	localparam logic [5:0] FL_FIN = 6'h01;
	localparam logic [5:0] FL_SYN = 6'h02;
	localparam logic [5:0] FL_ACK = 6'h10;

	localparam logic [10:0] MIN_FRAME  = 11'd40;
	// Protocol number 6 plus header length 20, both pseudo-header words.
	localparam logic [15:0] PSEUDO_SUM = 16'd26;
	localparam logic [7:0]  HDR_OFFSET_BYTE = 8'h50;
	localparam logic [15:0] WINDOW     = 16'hFFFF;

	typedef enum logic [3:0] {
		ST_CLOSED      = 4'b0001,
		ST_SYN_SENT    = 4'b0010,
		ST_ESTABLISHED = 4'b0100,
		ST_LAST_ACK    = 4'b1000
	} conn_state_t;

	localparam logic [1:0] CODE_CLOSED      = 2'd0;
	localparam logic [1:0] CODE_SYN_SENT    = 2'd1;
	localparam logic [1:0] CODE_ESTABLISHED = 2'd2;
	localparam logic [1:0] CODE_LAST_ACK    = 2'd3;

	typedef struct packed {
		logic [31:0] initial_seq;
		logic [31:0] local_ip;
		logic [31:0] remote_ip;
		logic [15:0] local_port;
		logic [15:0] remote_port;
	} cfg_t;

	typedef struct packed {
		logic        cmd;
		logic [10:0] frame_len;
		logic [5:0]  rx_flags;
		logic [31:0] rx_seq;
		logic [31:0] rx_ack;
	} item_t;

	typedef struct packed {
		logic        emit;
		logic [5:0]  tx_flags;
		logic [31:0] tx_seq;
		logic [31:0] tx_ack;
		logic [1:0]  new_state;
	} seg_t;

	function automatic logic [1:0] state_code(conn_state_t st);
		logic [1:0] code;
		case (st)
			ST_CLOSED:      code = CODE_CLOSED;
			ST_SYN_SENT:    code = CODE_SYN_SENT;
			ST_ESTABLISHED: code = CODE_ESTABLISHED;
			ST_LAST_ACK:    code = CODE_LAST_ACK;
			default:        code = CODE_CLOSED;
		endcase
		return code;
	endfunction

endpackage

>>> src/tcp_client_connection_fsm_unit.sv
// Top level of the TCP client connection unit: input register, logic, result register.
//
//  channel  | direction | handshake          | payload
//  s_*      | in        | s_tvalid/s_tready  | tuser: cmd; tdata: frame_len..rx_ack
//  m_*      | out       | m_tvalid/m_tready  | tdata: tx_flags..new_state
//  cfg_*    | in        | cfg_we             | cfg_addr, cfg_wdata
//
// One item per cycle unless the output stalls; a segment is sent from the result register.
// The connection state is updated as an item leaves the input register, so
// the next item in that register already sees it.
// Reset clears the state to closed, the valid bits, and the config registers to defaults.
// A stalled output holds the input register; input stays ready while either
// register can move.
module tcp_client_connection_fsm_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// frame_len[10:0], rx_flags[16:11], rx_seq[48:17], rx_ack[80:49], zero fill
	input  logic [tcfsm_pkg::InDataW-1:0]        s_tdata,
	// cmd[0]
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// tx_flags[5:0], tx_seq[37:6], tx_ack[69:38], tx_checksum[85:70], new_state[87:86]
	output logic [tcfsm_pkg::OutDataW-1:0]       m_tdata,
	input  logic                                 cfg_we,
	input  logic [tcfsm_pkg::CfgAddrW-1:0]       cfg_addr,
	input  logic [tcfsm_pkg::CfgDataW-1:0]       cfg_wdata
);

	tcfsm_pkg::cfg_t  cfg;
	tcfsm_pkg::item_t item_s1;
	tcfsm_pkg::seg_t  seg;
	tcfsm_pkg::seg_t  seg_s2;
	logic             valid_s1;
	logic             valid_s2;
	logic [15:0]      csum;
	logic [15:0]      csum_s2;
	logic             advance;

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	tcfsm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.cmd       <= s_tuser;
			item_s1.frame_len <= s_tdata[10:0];
			item_s1.rx_flags  <= s_tdata[16:11];
			item_s1.rx_seq    <= s_tdata[48:17];
			item_s1.rx_ack    <= s_tdata[80:49];
		end
	end

	tcfsm_conn u_conn (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && advance),
		.item   (item_s1),
		.cfg    (cfg),
		.seg    (seg)
	);

	tcfsm_csum u_csum (
		.cfg   (cfg),
		.flags (seg.tx_flags),
		.seq   (seg.tx_seq),
		.ack   (seg.tx_ack),
		.csum  (csum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && seg.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && seg.emit) begin
			seg_s2  <= seg;
			csum_s2 <= csum;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {seg_s2.new_state, csum_s2, seg_s2.tx_ack, seg_s2.tx_seq,
		seg_s2.tx_flags};

	// Each kind of sent segment belongs to exactly one following state.
	a_flags_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |->
			(seg_s2.tx_flags == tcfsm_pkg::FL_SYN
				&& seg_s2.new_state == tcfsm_pkg::CODE_SYN_SENT)
			|| (seg_s2.tx_flags == tcfsm_pkg::FL_ACK
				&& seg_s2.new_state == tcfsm_pkg::CODE_ESTABLISHED)
			|| (seg_s2.tx_flags == (tcfsm_pkg::FL_ACK | tcfsm_pkg::FL_FIN)
				&& seg_s2.new_state == tcfsm_pkg::CODE_LAST_ACK))
		else $error("sent segment flags disagree with new state");

	// Input back-pressure only when both registers are full and the output stalls.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && !m_tready)
		else $error("input stalled without a full pipeline");

	// A connect that leaves the input register produces a SYN next cycle.
	a_connect_syn: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && item_s1.cmd == tcfsm_pkg::CMD_CONNECT && seg.emit)
		|=> m_tvalid && seg_s2.tx_flags == tcfsm_pkg::FL_SYN)
		else $error("connect transaction lost its SYN");

endmodule

>>> src/tcfsm_cfg_regs.sv
// Configuration register bank written through the plain write port.
module tcfsm_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [tcfsm_pkg::CfgAddrW-1:0]       cfg_addr,
	input  logic [tcfsm_pkg::CfgDataW-1:0]       cfg_wdata,
	output tcfsm_pkg::cfg_t                      cfg
);

	tcfsm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.initial_seq <= tcfsm_pkg::RST_INITIAL_SEQ;
			cfg_q.local_ip    <= tcfsm_pkg::RST_LOCAL_IP;
			cfg_q.remote_ip   <= tcfsm_pkg::RST_REMOTE_IP;
			cfg_q.local_port  <= tcfsm_pkg::RST_LOCAL_PORT;
			cfg_q.remote_port <= tcfsm_pkg::RST_REMOTE_PORT;
		end else if (cfg_we) begin
			case (cfg_addr)
				tcfsm_pkg::CFG_INITIAL_SEQ: cfg_q.initial_seq <= cfg_wdata;
				tcfsm_pkg::CFG_LOCAL_IP:    cfg_q.local_ip    <= cfg_wdata;
				tcfsm_pkg::CFG_REMOTE_IP:   cfg_q.remote_ip   <= cfg_wdata;
				tcfsm_pkg::CFG_LOCAL_PORT:  cfg_q.local_port  <= cfg_wdata[15:0];
				tcfsm_pkg::CFG_REMOTE_PORT: cfg_q.remote_port <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> src/tcfsm_csum.sv
// Ones'-complement TCP checksum over pseudo-header and a payload-free header.
module tcfsm_csum (
	input  tcfsm_pkg::cfg_t cfg,
	input  logic [5:0]      flags,
	input  logic [31:0]     seq,
	input  logic [31:0]     ack,
	output logic [15:0]     csum
);

	logic [19:0] sum;
	logic [16:0] fold1;
	logic [15:0] fold2;

	// Thirteen 16-bit words stay below 2^20, so two end-around folds suffice.
	always_comb begin
		sum = {4'd0, cfg.local_ip[31:16]} + {4'd0, cfg.local_ip[15:0]}
			+ {4'd0, cfg.remote_ip[31:16]} + {4'd0, cfg.remote_ip[15:0]}
			+ {4'd0, tcfsm_pkg::PSEUDO_SUM}
			+ {4'd0, cfg.local_port} + {4'd0, cfg.remote_port}
			+ {4'd0, seq[31:16]} + {4'd0, seq[15:0]}
			+ {4'd0, ack[31:16]} + {4'd0, ack[15:0]}
			+ {4'd0, tcfsm_pkg::HDR_OFFSET_BYTE, 2'b00, flags}
			+ {4'd0, tcfsm_pkg::WINDOW};
		fold1 = {1'b0, sum[15:0]} + {13'd0, sum[19:16]};
		fold2 = fold1[15:0] + {15'd0, fold1[16]};
		csum  = ~fold2;
	end

endmodule

>>> src/tcfsm_conn.sv
// Connection state and sequence registers with the per-item next-state logic.
module tcfsm_conn (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  tcfsm_pkg::item_t item,
	input  tcfsm_pkg::cfg_t  cfg,
	output tcfsm_pkg::seg_t  seg
);

	tcfsm_pkg::conn_state_t state_q;
	tcfsm_pkg::conn_state_t state_d;
	logic [31:0] send_next_q;
	logic [31:0] send_next_d;
	logic [31:0] recv_next_q;
	logic [31:0] recv_next_d;
	logic        long_frame;
	logic [31:0] seq_inc;

	assign long_frame = (item.frame_len >= tcfsm_pkg::MIN_FRAME);
	assign seq_inc    = item.rx_seq + 32'd1;

	always_comb begin
		state_d      = state_q;
		send_next_d  = send_next_q;
		recv_next_d  = recv_next_q;
		seg.emit     = 1'b0;
		seg.tx_flags = tcfsm_pkg::FL_SYN;
		seg.tx_seq   = cfg.initial_seq;
		seg.tx_ack   = 32'd0;
		if (item.cmd == tcfsm_pkg::CMD_CONNECT) begin
			if (state_q == tcfsm_pkg::ST_CLOSED) begin
				state_d     = tcfsm_pkg::ST_SYN_SENT;
				send_next_d = cfg.initial_seq + 32'd1;
				seg.emit    = 1'b1;
			end
		end else if (long_frame) begin
			case (state_q)
				tcfsm_pkg::ST_SYN_SENT: begin
					if ((item.rx_flags & (tcfsm_pkg::FL_SYN | tcfsm_pkg::FL_ACK))
							== (tcfsm_pkg::FL_SYN | tcfsm_pkg::FL_ACK)) begin
						state_d      = tcfsm_pkg::ST_ESTABLISHED;
						recv_next_d  = seq_inc;
						seg.emit     = 1'b1;
						seg.tx_flags = tcfsm_pkg::FL_ACK;
						seg.tx_seq   = send_next_q;
						seg.tx_ack   = seq_inc;
					end
				end
				tcfsm_pkg::ST_ESTABLISHED: begin
					if ((item.rx_flags & tcfsm_pkg::FL_FIN) != 6'd0) begin
						state_d      = tcfsm_pkg::ST_LAST_ACK;
						recv_next_d  = seq_inc;
						seg.emit     = 1'b1;
						seg.tx_flags = tcfsm_pkg::FL_ACK | tcfsm_pkg::FL_FIN;
						seg.tx_seq   = send_next_q;
						seg.tx_ack   = seq_inc;
					end
				end
				tcfsm_pkg::ST_LAST_ACK: begin
					if ((item.rx_flags & tcfsm_pkg::FL_ACK) != 6'd0) begin
						state_d = tcfsm_pkg::ST_CLOSED;
					end
				end
				default: ;
			endcase
		end
		seg.new_state = tcfsm_pkg::state_code(state_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcfsm_pkg::ST_CLOSED;
			send_next_q <= 32'd0;
			recv_next_q <= 32'd0;
		end else if (step) begin
			state_q     <= state_d;
			send_next_q <= send_next_d;
			recv_next_q <= recv_next_d;
		end
	end

endmodule
